FILE: design/logistic_score_classifier_assert.svh
`ifndef LOGISTIC_SCORE_CLASSIFIER_ASSERT_SVH
`define LOGISTIC_SCORE_CLASSIFIER_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define LSC_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lsc check failed");

// Checks that a condition holds in the cycle after its trigger.
`define LSC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lsc check failed");

`endif

FILE: design/lsc_pkg.sv
package lsc_pkg;

   localparam int VALUE_W     = 16;
   localparam int PROD_W      = 32;
   localparam int ACC_W       = 40;
   localparam int PROB_W      = 16;
   localparam int TABLE_SIZE  = 1024;
   localparam int TABLE_IDX_W = 10;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_FEATURE = 1'b1;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic [95:0] EXP_STEP = 96'd4228380000;

   typedef struct packed {
      logic                       first;
      logic                       last;
      logic                       excess;
      logic signed [VALUE_W-1:0]  bias;
      logic signed [PROD_W-1:0]   prod;
   } feat_entry_type;

   typedef logic [PROB_W-1:0] sig_table_type [TABLE_SIZE];

   // Restoring long division, only ever evaluated while the table is built.
   function automatic logic [95:0] quotient_of(input logic [95:0] num,
                                               input logic [95:0] den);
      logic [95:0] q;
      logic [95:0] r;
      q = '0;
      r = '0;
      for (int i = 95; i >= 0; i--) begin
         r = {r[94:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      logic [95:0]   e;
      logic [95:0]   d;
      logic [95:0]   p;
      e = 96'd1 << 32;
      for (int k = 0; k <= 512; k++) begin
         d = (96'd1 << 32) + e;
         p = quotient_of((96'd1 << 48) + (d >> 1), d);
         if (p > 96'd65535) begin
            p = 96'd65535;
         end
         if (k < 512) begin
            t[512 + k] = p[15:0];
         end
         if (k >= 1) begin
            t[512 - k] = 16'(32'd65536 - p[31:0]);
         end
         e = (e * EXP_STEP + (96'd1 << 31)) >> 32;
      end
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

FILE: design/lsc_front.sv
module lsc_front #(
   parameter int DIM = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   input  logic [4:0]             req_slot,
   input  logic signed [15:0]     req_value,
   input  logic                   req_last,
   input  logic                   queue_full,
   output logic                   push,
   output lsc_pkg::feat_entry_type push_entry
);
   import lsc_pkg::*;

   localparam int SLOTS      = (DIM < 31) ? DIM + 1 : 32;
   localparam int SLOT_IDX_W = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(DIM + 1);

   logic signed [VALUE_W-1:0] weight_ff [SLOTS];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      excess_ff;
   logic                      excess_in;
   logic                      accept;
   logic                      load_en;
   logic                      feat_en;
   logic                      in_use;
   logic                      in_store;
   logic [CNT_W:0]            rd_next;
   logic [SLOT_IDX_W-1:0]     rd_idx;
   logic [SLOT_IDX_W-1:0]     wr_idx;
   logic signed [VALUE_W-1:0] weight_rd;
   logic signed [PROD_W-1:0]  product;

   assign accept   = req_valid && !queue_full;
   assign load_en  = accept && (req_cmd == CMD_LOAD) && (32'(req_slot) <= 32'(DIM));
   assign feat_en  = accept && (req_cmd == CMD_FEATURE);
   assign wr_idx   = req_slot[SLOT_IDX_W-1:0];
   assign rd_next  = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign in_store = 32'(rd_next) < 32'(SLOTS);
   assign rd_idx   = rd_next[SLOT_IDX_W-1:0];
   assign in_use   = 32'(count_ff) < 32'(DIM);

   always_comb begin
      weight_rd = '0;
      if (in_store) begin
         weight_rd = weight_ff[rd_idx];
      end
   end

   assign product = weight_rd * req_value;

   always_comb begin
      count_in  = count_ff;
      excess_in = excess_ff;
      if (feat_en) begin
         if (req_last) begin
            count_in  = '0;
            excess_in = 1'b0;
         end else if (in_use) begin
            count_in = rd_next[CNT_W-1:0];
         end else begin
            excess_in = 1'b1;
         end
      end
   end

   always_comb begin
      push_entry.first  = (count_ff == '0) && !excess_ff;
      push_entry.last   = req_last;
      push_entry.excess = excess_ff || !in_use;
      push_entry.bias   = weight_ff[0];
      push_entry.prod   = in_use ? product : '0;
   end

   assign push = feat_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         excess_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            weight_ff[i] <= '0;
         end
      end else begin
         count_ff  <= count_in;
         excess_ff <= excess_in;
         if (load_en) begin
            weight_ff[wr_idx] <= req_value;
         end
      end
   end

endmodule

FILE: design/lsc_queue.sv
`include "logistic_score_classifier_assert.svh"

module lsc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lsc_pkg::feat_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output lsc_pkg::feat_entry_type pop_entry
);
   import lsc_pkg::*;

   feat_entry_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W:0]    count_ff;
   logic [QPTR_W:0]    count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The queue never takes a transfer while full, nor gives one while empty.
   `LSC_ASSERT_SAME(a_no_push_full, clock, reset, push, !full)
   `LSC_ASSERT_SAME(a_no_pop_empty, clock, reset, pop, pop_valid)
   `LSC_ASSERT_SAME(a_ptr_empty, clock, reset, count_ff == '0, rd_ptr_ff == wr_ptr_ff)
   `LSC_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

FILE: design/lsc_back.sv
module lsc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  lsc_pkg::feat_entry_type q_entry,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [15:0]             rsp_probability,
   output logic signed [39:0]      rsp_score,
   output logic                    rsp_overflow_flag
);
   import lsc_pkg::*;

   logic                     advance;
   logic [ACC_W-1:0]         base;
   logic [ACC_W:0]           sum;
   logic [ACC_W-1:0]         sat;
   logic [ACC_W-1:0]         acc_ff;
   logic                     res_valid_ff;
   logic [ACC_W-1:0]         score_ff;
   logic                     flag_ff;
   logic                     in_range;
   logic [TABLE_IDX_W-1:0]   rom_idx;
   logic                     rsp_valid_ff;
   logic [PROB_W-1:0]        rsp_probability_ff;
   logic [ACC_W-1:0]         rsp_score_ff;
   logic                     rsp_flag_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign q_pop   = q_valid && advance;

   always_comb begin
      base = acc_ff;
      if (q_entry.first) begin
         base = {{(ACC_W-VALUE_W-8){q_entry.bias[VALUE_W-1]}}, q_entry.bias, 8'd0};
      end
      sum = {base[ACC_W-1], base}
          + {{(ACC_W+1-PROD_W){q_entry.prod[PROD_W-1]}}, q_entry.prod};
      sat = sum[ACC_W-1:0];
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         res_valid_ff <= q_pop && q_entry.last;
         if (q_pop) begin
            acc_ff <= q_entry.last ? '0 : sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && q_pop) begin
         score_ff <= sat;
         flag_ff  <= q_entry.excess;
      end
   end

   // Scores inside [-8, 8) map linearly onto the table; others clamp to an end.
   assign in_range = (&score_ff[ACC_W-1:19]) || !(|score_ff[ACC_W-1:19]);

   always_comb begin
      if (in_range) begin
         rom_idx = {~score_ff[19], score_ff[18:10]};
      end else if (score_ff[ACC_W-1]) begin
         rom_idx = '0;
      end else begin
         rom_idx = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_probability_ff <= SIG_TABLE[rom_idx];
         rsp_score_ff       <= score_ff;
         rsp_flag_ff        <= flag_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_probability   = rsp_probability_ff;
   assign rsp_score         = rsp_score_ff;
   assign rsp_overflow_flag = rsp_flag_ff;

endmodule

FILE: design/logistic_score_classifier.sv
// Logistic regression scorer with a weight store of a bias and DIM weights.
// Request channel (req_*): cmd low loads req_value into weight slot req_slot,
// slot 0 being the bias; cmd high streams one feature, req_last marking the
// final feature of a vector. Every request is a transfer when req_valid is
// high and req_stall is low, and one may be taken in every cycle.
// Response channel (rsp_*): one response per vector, carrying the saturated
// Q24.16 score, its sigmoid in Q0.16 and a flag for surplus features.
// The front end reads the weights and forms each product as it takes the
// transfer; a four-entry queue sits between it and the back end, which
// accumulates, then reads the sigmoid ROM into the output register.
// The last feature passes the queue, result register and output register
// before rsp_valid rises; throughput is one request per cycle while req_stall
// is low, set by the single multiplier and accumulator in use per feature.
// While rsp_stall holds a valid response the back end freezes, the queue fills, and once it
// holds four entries req_stall rises until the response is taken.
// Synchronous reset clears all weights to zero, empties the queue and drops
// any vector in progress; requests are taken from the first cycle after it.
module logistic_score_classifier #(
   parameter int DIM = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [4:0]         req_slot,
   input  logic signed [15:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_probability,
   output logic signed [39:0] rsp_score,
   output logic               rsp_overflow_flag
);
   import lsc_pkg::*;

   logic           push;
   logic           full;
   logic           pop;
   logic           pop_valid;
   feat_entry_type push_entry;
   feat_entry_type pop_entry;

   assign req_stall = full;

   lsc_front #(
      .DIM (DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_cmd    (req_cmd),
      .req_slot   (req_slot),
      .req_value  (req_value),
      .req_last   (req_last),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   lsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   lsc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (pop_valid),
      .q_entry           (pop_entry),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_probability   (rsp_probability),
      .rsp_score         (rsp_score),
      .rsp_overflow_flag (rsp_overflow_flag)
   );

endmodule

FILE: tb/logistic_score_classifier_test.sv
module logistic_score_classifier_test;
   import lsc_pkg::*;

   localparam int DIM = 16;
   localparam int TARGET_ITEMS = 550;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD = 80;
   localparam longint unsigned EXP_DECAY = 64'd4228380000;
   localparam longint SIG_SPAN = 64'sd524288;
   localparam longint SCORE_MAX = 64'sd549755813887;
   localparam longint SCORE_MIN = -64'sd549755813888;

   typedef struct {
      logic [15:0] prob;
      logic [39:0] score;
      logic        ovf;
   } score_result_type;

   typedef struct {
      logic               cmd;
      logic [4:0]         slot;
      logic signed [15:0] value;
      logic               last;
      int                 reps;
      bit                 typed;
      score_result_type   want;
   } stim_row_type;

   localparam score_result_type NO_RESULT = '{16'd0, 40'd0, 1'b0};
   localparam score_result_type ZERO_SCORE = '{16'd32768, 40'd0, 1'b0};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd = CMD_LOAD;
   logic [4:0]         req_slot = 5'd0;
   logic signed [15:0] req_value = 16'sd0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_probability;
   logic signed [39:0] rsp_score;
   logic               rsp_overflow_flag;

   logic [15:0]        prob_rom [1024];
   logic signed [15:0] weight_copy [DIM+1];
   longint             acc_copy;
   int                 features_in_vector;
   bit                 surplus_in_vector;

   score_result_type   pending_scores [$];
   score_result_type   oldest;
   stim_row_type       directed_rows [24];

   int  mismatches = 0;
   int  items_sent = 0;
   int  vectors_scored = 0;
   int  surplus_vectors = 0;
   int  clipped_scores = 0;
   int  quiet_cycles = 0;
   bit  sender_idle = 1'b1;
   bit  recv_idle = 1'b1;
   bit  hold_start = 1'b0;
   int  hold_left = 0;
   int  burst_left = 0;

   logistic_score_classifier #(.DIM(DIM)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_slot(req_slot),
      .req_value(req_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_probability(rsp_probability),
      .rsp_score(rsp_score),
      .rsp_overflow_flag(rsp_overflow_flag)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void build_prob_rom();
      longint unsigned e;
      longint unsigned d;
      longint unsigned p;
      e = 64'd1 << 32;
      for (int k = 0; k <= 512; k++) begin
         d = (64'd1 << 32) + e;
         p = ((64'd1 << 48) + (d >> 1)) / d;
         if (p > 64'd65535) begin
            p = 64'd65535;
         end
         if (k < 512) begin
            prob_rom[512 + k] = p[15:0];
         end
         if (k >= 1) begin
            prob_rom[512 - k] = 16'(64'd65536 - p);
         end
         e = (e * EXP_DECAY + (64'd1 << 31)) >> 32;
      end
   endfunction

   function automatic logic [15:0] sigmoid_of(longint s);
      if (s < -SIG_SPAN) begin
         return prob_rom[0];
      end
      if (s >= SIG_SPAN) begin
         return prob_rom[1023];
      end
      return prob_rom[(s + SIG_SPAN) >>> 10];
   endfunction

   function automatic logic signed [15:0] rand_value();
      logic signed [15:0] v;
      case ($urandom_range(0, 7))
         0, 1: v = 16'($urandom_range(0, 65535));
         2: begin
            case ($urandom_range(0, 3))
               0: v = 16'sh7FFF;
               1: v = 16'sh8000;
               2: v = 16'sd0;
               default: v = -16'sd1;
            endcase
         end
         default: v = 16'($urandom_range(0, 600)) - 16'sd300;
      endcase
      return v;
   endfunction

   // Bias is taken on the first feature of a vector; surplus features only set the flag.
   task automatic score_item(input logic cmd, input logic [4:0] slot,
                             input logic signed [15:0] value, input logic last,
                             output bit emitted, output score_result_type r);
      longint prod;
      emitted = 1'b0;
      r = NO_RESULT;
      if (cmd == CMD_LOAD) begin
         if (slot <= DIM) begin
            weight_copy[slot] = value;
         end
      end else begin
         if (features_in_vector == 0 && !surplus_in_vector) begin
            acc_copy = longint'(weight_copy[0]) * 256;
         end
         if (features_in_vector < DIM) begin
            prod = longint'(weight_copy[features_in_vector + 1]) * longint'(value);
            acc_copy = acc_copy + prod;
            if (acc_copy > SCORE_MAX) begin
               acc_copy = SCORE_MAX;
            end else if (acc_copy < SCORE_MIN) begin
               acc_copy = SCORE_MIN;
            end
            features_in_vector++;
         end else begin
            surplus_in_vector = 1'b1;
         end
         if (last) begin
            emitted = 1'b1;
            r.prob = sigmoid_of(acc_copy);
            r.score = acc_copy[39:0];
            r.ovf = surplus_in_vector;
            vectors_scored++;
            if (surplus_in_vector) begin
               surplus_vectors++;
            end
            if (acc_copy < -SIG_SPAN || acc_copy >= SIG_SPAN) begin
               clipped_scores++;
            end
            acc_copy = 0;
            features_in_vector = 0;
            surplus_in_vector = 1'b0;
         end
      end
   endtask

   task automatic send_req(input logic cmd, input logic [4:0] slot,
                           input logic signed [15:0] value, input logic last,
                           input bit typed, input score_result_type typed_want);
      int               gap;
      bit               emitted;
      score_result_type r;
      gap = 0;
      if (sender_idle && hold_left == 0 && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_slot <= slot;
      req_value <= value;
      req_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      score_item(cmd, slot, value, last, emitted, r);
      if (emitted) begin
         pending_scores.insert(pending_scores.size(), typed ? typed_want : r);
      end
      if (cmd == CMD_FEATURE || slot <= DIM) begin
         items_sent++;
      end
   endtask

   task automatic send_random_load(input bit noisy_last);
      logic [4:0] slot;
      if ($urandom_range(0, 7) == 0) begin
         slot = 5'($urandom_range(0, 31));
      end else begin
         slot = 5'($urandom_range(0, DIM));
      end
      send_req(CMD_LOAD, slot, rand_value(), noisy_last, 1'b0, NO_RESULT);
   endtask

   task automatic send_random_vector();
      int len;
      case ($urandom_range(0, 9))
         0: len = $urandom_range(DIM + 1, DIM + 4);
         1: len = $urandom_range(1, 3);
         default: len = $urandom_range(1, DIM);
      endcase
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_random_load($urandom_range(0, 1));
         end
         send_req(CMD_FEATURE, 5'($urandom_range(0, 31)), rand_value(), i == len - 1,
                  1'b0, NO_RESULT);
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch in %s: got %0d, expected %0d (response %0d)",
               what, got, want, vectors_scored);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
         burst_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scores.size() == 0) begin
            report_mismatch("unexpected response, score", longint'(rsp_score), 0);
         end else begin
            oldest = pending_scores.pop_front();
            if (rsp_probability !== oldest.prob) begin
               report_mismatch("probability", longint'(rsp_probability),
                               longint'(oldest.prob));
            end
            if (rsp_score !== oldest.score) begin
               report_mismatch("score", longint'(rsp_score),
                               longint'($signed(oldest.score)));
            end
            if (rsp_overflow_flag !== oldest.ovf) begin
               report_mismatch("overflow flag", longint'(rsp_overflow_flag),
                               longint'(oldest.ovf));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("no transfer for %0d cycles, %0d responses outstanding",
                  WATCHDOG_LIMIT, pending_scores.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      bit hold_done;
      bit pause_done;
      hold_done = 1'b0;
      pause_done = 1'b0;
      build_prob_rom();
      for (int i = 0; i <= DIM; i++) begin
         weight_copy[i] = 16'sd0;
      end
      acc_copy = 0;
      features_in_vector = 0;
      surplus_in_vector = 1'b0;

      // Weights 1, 2 and 16 stay set through the surplus vector, which clamps to the low end of the table.
      directed_rows = '{
         '{CMD_FEATURE, 5'd0,  16'sd0,      1'b1, 1,  1'b1, ZERO_SCORE},
         '{CMD_LOAD,    5'd0,  16'sh7FFF,   1'b1, 1,  1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd0,  16'sd0,      1'b1, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd0,  16'sh8000,   1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd0,  16'sd0,      1'b1, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd1,  16'sh8000,   1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd16, 16'sh7FFF,   1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd31, 16'sh8000,   1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd2,  16'sh7FFF,   1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd0,  16'sh7FFF,   1'b1, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd0,  16'sd0,      1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd17, 16'sd1234,   1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd31, -16'sd1,     1'b1, 1,  1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd0,  16'sd1,      1'b0, 15, 1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd0,  16'sh8000,   1'b0, 3,  1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd0,  16'sd100,    1'b1, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd0,  16'sd512,    1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd0,  16'sd0,      1'b1, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd0,  -16'sd2048,  1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd0,  16'sd0,      1'b1, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd0,  16'sd2047,   1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd0,  16'sd0,      1'b1, 1,  1'b0, NO_RESULT},
         '{CMD_LOAD,    5'd0,  16'sd2048,   1'b0, 1,  1'b0, NO_RESULT},
         '{CMD_FEATURE, 5'd0,  16'sd0,      1'b1, 1,  1'b0, NO_RESULT}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         for (int n = 0; n < directed_rows[r].reps; n++) begin
            send_req(directed_rows[r].cmd, directed_rows[r].slot, directed_rows[r].value,
                     directed_rows[r].last && n == directed_rows[r].reps - 1,
                     directed_rows[r].typed, directed_rows[r].want);
         end
      end

      while (items_sent < TARGET_ITEMS) begin
         sender_idle = items_sent < 450 && !(items_sent >= 300 && items_sent < 360);
         recv_idle = sender_idle;
         if (!hold_done && items_sent >= 150) begin
            // The receiver holds off while features keep coming, so the input backs up.
            hold_done = 1'b1;
            sender_idle = 1'b0;
            hold_start = 1'b1;
            for (int i = 0; i < 20; i++) begin
               send_req(CMD_FEATURE, 5'($urandom_range(0, 31)), rand_value(),
                        i == 19 || $urandom_range(0, 3) == 0, 1'b0, NO_RESULT);
            end
         end
         if (!pause_done && items_sent >= 250) begin
            pause_done = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_scores.size() != 0) @(posedge clock);
         end
         repeat ($urandom_range(0, 3)) begin
            send_random_load($urandom_range(0, 9) == 0);
         end
         send_random_vector();
      end
      req_valid <= 1'b0;

      while (pending_scores.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d requests and %0d scored vectors: %0d with surplus features,",
               items_sent, vectors_scored, surplus_vectors);
      $display("%0d outside the sigmoid table range, plus a long response hold-off",
               clipped_scores);
      if (mismatches == 0 && pending_scores.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
